// File: rtl/core/csot_pkg.sv
// Shared widths and types for the circle versus screen overlap test.
`default_nettype none
package csot_pkg;

   localparam int CoordWidth  = 14;   // centre coordinates
   localparam int DimWidth    = 13;   // screen dimensions and radius
   localparam int OffWidth    = 16;   // edge offsets relative to the centre
   localparam int SqWidth     = 28;   // square of an offset
   localparam int RadSqWidth  = 26;   // square of the radius
   localparam int QWidth      = 30;   // r^2 minus a squared offset

   localparam logic CsrWidth  = 1'b0;
   localparam logic CsrHeight = 1'b1;

   typedef logic signed [OffWidth-1:0] off_type;
   typedef logic        [SqWidth-1:0]  sq_type;
   typedef logic signed [QWidth-1:0]   q_type;

   // One edge's interval test operands
   typedef struct packed {
      logic   enable;     // edge has non-zero length
      q_type  q;          // squared half chord on the edge's line
      logic   lo_nonpos;  // lower bound <= 0
      sq_type lo_sq;
      logic   hi_nonneg;  // upper bound >= 0
      sq_type hi_sq;
   } edge_type;

endpackage
`default_nettype wire

// File: rtl/core/csot_edge.sv
// Chord versus edge interval test for one screen edge.
`default_nettype none
module csot_edge
   import csot_pkg::*;
(
   input  wire edge_type edge_op,
   output logic          hit
);

   logic q_pos;
   logic ge_lo;
   logic le_lo;
   logic ge_hi;
   logic le_hi;
   logic pos_in;
   logic neg_in;

   // compare the squared half chord against the squared bounds
   always_comb begin
      q_pos  = edge_op.q > q_type'(0);
      ge_lo  = edge_op.q >= $signed({2'b00, edge_op.lo_sq});
      le_lo  = edge_op.q <= $signed({2'b00, edge_op.lo_sq});
      ge_hi  = edge_op.q >= $signed({2'b00, edge_op.hi_sq});
      le_hi  = edge_op.q <= $signed({2'b00, edge_op.hi_sq});
      // +sqrt(q) inside [lo, hi]
      pos_in = (edge_op.lo_nonpos | ge_lo) & edge_op.hi_nonneg & le_hi;
      // -sqrt(q) inside [lo, hi]
      neg_in = edge_op.lo_nonpos & le_lo & (edge_op.hi_nonneg | ge_hi);
      hit    = edge_op.enable & q_pos & (pos_in | neg_in);
   end

endmodule
`default_nettype wire

// File: rtl/core/circle_screen_overlap_test_top.sv
// Top level of the circle versus screen rectangle overlap test.
//
//   channel   ports                                        handshake
//   request   start, busy, req_center_x/_y, req_circle_radius  start & !busy
//   result    rsp_valid, rsp_visible                       one-cycle strobe
//   config    csr_write_enable, csr_index, csr_write_data  write enable
//
// Four register stages: offsets, squares, chord terms, edge compares.
// One circle may enter every cycle; its result strobes out of the edge-compare stage.
// The multipliers in the squaring stage set the clock period.
// busy is always low; the receiver cannot stall, so nothing is held.
// Synchronous reset clears the valid bits and loads 600 x 600.
`default_nettype none
module circle_screen_overlap_test_top
   import csot_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire signed [CoordWidth-1:0]  req_center_x,
   input  wire signed [CoordWidth-1:0]  req_center_y,
   input  wire        [DimWidth-1:0]    req_circle_radius,
   output logic                         rsp_valid,
   output logic                         rsp_visible,
   input  wire                          csr_write_enable,
   input  wire                          csr_index,
   input  wire        [DimWidth-1:0]    csr_write_data
);

   logic [DimWidth-1:0] width_ff, height_ff;

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   off_type             lox_ff, hix_ff, loy_ff, hiy_ff;
   logic [DimWidth-1:0] r1_ff;
   logic                wen1_ff, hen1_ff, inside1_ff;

   sq_type              lox2_ff, hix2_ff, loy2_ff, hiy2_ff;
   logic [RadSqWidth-1:0] r2_ff;
   logic                lxn_ff, hxp_ff, lyn_ff, hyp_ff;
   logic                wen2_ff, hen2_ff, inside2_ff;

   edge_type            edge_ff [4];
   logic                inside3_ff;
   logic                visible_ff;

   off_type             cx_in, cy_in, w_in, h_in;
   logic [DimWidth-2:0] m_in;
   logic                inside_in;
   logic signed [2*OffWidth-1:0] lox2_in, hix2_in, loy2_in, hiy2_in;
   logic [3:0]          hit;

   assign busy = 1'b0;

   // write configuration beats
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DimWidth'(600);
         height_ff <= DimWidth'(600);
      end else if (csr_write_enable) begin
         if (csr_index == CsrWidth) width_ff <= csr_write_data;
         else                       height_ff <= csr_write_data;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1: edge offsets relative to the centre, inside test
   always_comb begin
      cx_in = OffWidth'(req_center_x);
      cy_in = OffWidth'(req_center_y);
      w_in  = $signed({3'b000, width_ff});
      h_in  = $signed({3'b000, height_ff});
      m_in  = (height_ff[DimWidth-1:1] < width_ff[DimWidth-1:1]) ?
              height_ff[DimWidth-1:1] : width_ff[DimWidth-1:1];
      inside_in = (cx_in > off_type'(0)) && (cx_in < w_in) &&
                  (cy_in > off_type'(0)) && (cy_in < h_in) &&
                  (req_circle_radius < {1'b0, m_in});
   end

   always_ff @(posedge clock) begin
      lox_ff     <= -cx_in;
      hix_ff     <= w_in - cx_in;
      loy_ff     <= -cy_in;
      hiy_ff     <= h_in - cy_in;
      r1_ff      <= req_circle_radius;
      wen1_ff    <= width_ff != '0;
      hen1_ff    <= height_ff != '0;
      inside1_ff <= inside_in;
   end

   // stage 2: squares and bound signs
   always_comb begin
      lox2_in = lox_ff * lox_ff;
      hix2_in = hix_ff * hix_ff;
      loy2_in = loy_ff * loy_ff;
      hiy2_in = hiy_ff * hiy_ff;
   end

   always_ff @(posedge clock) begin
      lox2_ff    <= lox2_in[SqWidth-1:0];
      hix2_ff    <= hix2_in[SqWidth-1:0];
      loy2_ff    <= loy2_in[SqWidth-1:0];
      hiy2_ff    <= hiy2_in[SqWidth-1:0];
      r2_ff      <= RadSqWidth'(r1_ff) * RadSqWidth'(r1_ff);
      lxn_ff     <= lox_ff <= off_type'(0);
      hxp_ff     <= hix_ff >= off_type'(0);
      lyn_ff     <= loy_ff <= off_type'(0);
      hyp_ff     <= hiy_ff >= off_type'(0);
      wen2_ff    <= wen1_ff;
      hen2_ff    <= hen1_ff;
      inside2_ff <= inside1_ff;
   end

   // stage 3: squared half chord on each edge's line
   always_ff @(posedge clock) begin
      // bottom edge, x interval
      edge_ff[0] <= '{enable: wen2_ff,
                      q: $signed({4'b0000, r2_ff}) - $signed({2'b00, loy2_ff}),
                      lo_nonpos: lxn_ff, lo_sq: lox2_ff,
                      hi_nonneg: hxp_ff, hi_sq: hix2_ff};
      // left edge, y interval
      edge_ff[1] <= '{enable: hen2_ff,
                      q: $signed({4'b0000, r2_ff}) - $signed({2'b00, lox2_ff}),
                      lo_nonpos: lyn_ff, lo_sq: loy2_ff,
                      hi_nonneg: hyp_ff, hi_sq: hiy2_ff};
      // right edge, y interval
      edge_ff[2] <= '{enable: hen2_ff,
                      q: $signed({4'b0000, r2_ff}) - $signed({2'b00, hix2_ff}),
                      lo_nonpos: lyn_ff, lo_sq: loy2_ff,
                      hi_nonneg: hyp_ff, hi_sq: hiy2_ff};
      // top edge, x interval
      edge_ff[3] <= '{enable: wen2_ff,
                      q: $signed({4'b0000, r2_ff}) - $signed({2'b00, hiy2_ff}),
                      lo_nonpos: lxn_ff, lo_sq: lox2_ff,
                      hi_nonneg: hxp_ff, hi_sq: hix2_ff};
      inside3_ff <= inside2_ff;
   end

   // stage 4: edge compares
   for (genvar e = 0; e < 4; e++) begin : g_edge
      csot_edge u_edge (
         .edge_op (edge_ff[e]),
         .hit     (hit[e])
      );
   end

   always_ff @(posedge clock) begin
      visible_ff <= (|hit) | inside3_ff;
   end

   assign rsp_valid   = v4_ff;
   assign rsp_visible = visible_ff;

endmodule
`default_nettype wire

// File: tb/circle_screen_overlap_test_checker.sv
// Checker for the circle versus screen overlap test: predicts and compares results.
`timescale 1ns / 1ps
module circle_screen_overlap_test_checker
   import csot_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire                         busy,
   input  wire signed [CoordWidth-1:0] req_center_x,
   input  wire signed [CoordWidth-1:0] req_center_y,
   input  wire        [DimWidth-1:0]   req_circle_radius,
   input  wire                         rsp_valid,
   input  wire                         rsp_visible,
   input  wire                         csr_write_enable,
   input  wire                         csr_index,
   input  wire        [DimWidth-1:0]   csr_write_data,
   output int                          fail_count,
   output int                          pending
);

   logic [DimWidth-1:0] width_copy;
   logic [DimWidth-1:0] height_copy;
   bit                  visible_queue[$];

   // Truncated square root with 16 fractional bits, digit by digit
   function automatic longint unsigned root_q16(longint unsigned v);
      longint unsigned root;
      longint unsigned rem;
      longint unsigned pair;
      longint unsigned trial;
      root = 0;
      rem  = 0;
      for (int i = 43; i >= 0; i--) begin
         pair  = (i >= 16) ? ((v >> (2 * (i - 16))) & 64'd3) : 64'd0;
         rem   = (rem << 2) | pair;
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // Segment against circle at the origin, on scaled numerators
   function automatic bit segment_crossed(longint r, longint x1, longint y1,
                                          longint x2, longint y2);
      longint dx, dy, dr2, d, chk, s, sg, ady, bx, by;
      longint nx1, ny1, nx2, ny2, lx, hx, ly, hy;
      dx  = x2 - x1;
      dy  = y2 - y1;
      dr2 = dx * dx + dy * dy;
      d   = x1 * y2 - x2 * y1;
      chk = r * r * dr2 - d * d;
      if (chk <= 0)
         return 1'b0;
      s   = longint'(root_q16(longint'(chk)));
      sg  = (dy < 0) ? -1 : 1;
      ady = (dy < 0) ? -dy : dy;
      bx  = (d * dy) * 65536;
      by  = (-d * dx) * 65536;
      nx1 = bx + sg * dx * s;
      ny1 = by + ady * s;
      nx2 = bx - sg * dx * s;
      ny2 = by - ady * s;
      lx  = x1 * dr2 * 65536;
      hx  = x2 * dr2 * 65536;
      ly  = y1 * dr2 * 65536;
      hy  = y2 * dr2 * 65536;
      if (nx1 <= hx && nx1 >= lx && ny1 <= hy && ny1 >= ly)
         return 1'b1;
      if (nx2 <= hx && nx2 >= lx && ny2 <= hy && ny2 >= ly)
         return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit circle_on_screen(logic signed [CoordWidth-1:0] cxv,
                                           logic signed [CoordWidth-1:0] cyv,
                                           logic [DimWidth-1:0] rv,
                                           logic [DimWidth-1:0] wv,
                                           logic [DimWidth-1:0] hv);
      longint cx, cy, r, w, h, m;
      bit     vis;
      cx  = longint'(cxv);
      cy  = longint'(cyv);
      r   = longint'(rv);
      w   = longint'(wv);
      h   = longint'(hv);
      vis = segment_crossed(r, -cx, -cy, w - cx, -cy) ||
            segment_crossed(r, -cx, -cy, -cx, h - cy) ||
            segment_crossed(r, w - cx, -cy, w - cx, h - cy) ||
            segment_crossed(r, -cx, h - cy, w - cx, h - cy);
      // Fully inside: centre strictly within and radius below the smaller half
      if (!vis && cx > 0 && cx < w && cy > 0 && cy < h) begin
         m = ((h / 2) < (w / 2)) ? (h / 2) : (w / 2);
         if (r < m)
            vis = 1'b1;
      end
      return vis;
   endfunction

   assign pending = visible_queue.size();

   // Track registers, queue predictions, compare each result beat
   always @(posedge clock) begin
      if (reset) begin
         width_copy  <= 13'd600;
         height_copy <= 13'd600;
         fail_count  <= 0;
         visible_queue.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CsrWidth)
               width_copy <= csr_write_data;
            else if (csr_index == CsrHeight)
               height_copy <= csr_write_data;
         end
         if (start && !busy)
            visible_queue.push_back(circle_on_screen(req_center_x, req_center_y,
                                    req_circle_radius, width_copy, height_copy));
         if (rsp_valid) begin
            if (visible_queue.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual visible=%0b",
                        $time, rsp_visible);
               fail_count <= fail_count + 1;
            end else begin
               bit want;
               want = visible_queue.pop_front();
               if (rsp_visible !== want) begin
                  $display("%0t: visible mismatch, expected %0b, actual %0b",
                           $time, want, rsp_visible);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: tb/circle_screen_overlap_test_top_tb.sv
// Testbench top for the circle versus screen overlap test: stimulus and verdict.
`timescale 1ns / 1ps
module circle_screen_overlap_test_top_tb;
   import csot_pkg::*;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [CoordWidth-1:0] req_center_x;
   logic signed [CoordWidth-1:0] req_center_y;
   logic        [DimWidth-1:0]   req_circle_radius;
   logic                         rsp_valid;
   logic                         rsp_visible;
   logic                         csr_write_enable;
   logic                         csr_index;
   logic        [DimWidth-1:0]   csr_write_data;
   int                           fail_count;
   int                           pending;
   int                           circles_sent;
   int                           settings_done;

   circle_screen_overlap_test_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_circle_radius(req_circle_radius),
      .rsp_valid(rsp_valid), .rsp_visible(rsp_visible),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   circle_screen_overlap_test_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_circle_radius(req_circle_radius),
      .rsp_valid(rsp_valid), .rsp_visible(rsp_visible),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   // Present one circle and hold it until accepted; called at a rising edge
   task automatic send_circle(int cx, int cy, int r);
      start             <= 1'b1;
      req_center_x      <= CoordWidth'(cx);
      req_center_y      <= CoordWidth'(cy);
      req_circle_radius <= DimWidth'(r);
      do @(posedge clock); while (busy);
      circles_sent++;
   endtask

   task automatic idle_gap(bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic idx, int value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= DimWidth'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait out the pipeline before touching the registers
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic int clamp_coord(int v);
      if (v < -8192) return -8192;
      if (v > 8191) return 8191;
      return v;
   endfunction

   initial begin
      static int widths[10]  = '{600, 1, 4096, 0, 8191, 4096, 1, 0, 37, 300};
      static int heights[10] = '{600, 1, 4096, 0, 8191, 1, 4096, 600, 900, 301};
      int w, h, cx, cy, r;
      start            <= 1'b0;
      req_center_x     <= '0;
      req_center_y     <= '0;
      req_circle_radius <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CsrWidth;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      circles_sent     = 0;
      settings_done    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 10; p++) begin
         w = widths[p];
         h = heights[p];
         if (p == 9) begin
            w = $urandom_range(1, 4096);
            h = $urandom_range(1, 4096);
         end
         write_reg(CsrWidth, w);
         write_reg(CsrHeight, h);
         if (p == 0) begin
            // Directed: field extremes, tangents, inside, corners
            send_circle(-8192, -8192, 0);
            send_circle(8191, 8191, 8191);
            send_circle(-8192, 8191, 8191);
            send_circle(8191, -8192, 0);
            send_circle(300, 300, 0);
            send_circle(300, 300, 299);
            send_circle(300, 300, 300);
            send_circle(300, -100, 100);
            send_circle(300, -100, 101);
            send_circle(-100, 300, 100);
            send_circle(700, 300, 100);
            send_circle(300, 700, 100);
            send_circle(300, 700, 101);
            send_circle(0, 0, 0);
            send_circle(0, 0, 1);
            send_circle(600, 600, 1);
            send_circle(-1, -1, 1);
            send_circle(-1, -1, 2);
            send_circle(300, 300, 8191);
            send_circle(0, 300, 5);
            idle_gap(1'b1);
         end
         // Random: mostly near the screen, some anywhere
         for (int k = 0; k < 170; k++) begin
            if ($urandom_range(0, 9) < 7) begin
               cx = clamp_coord($urandom_range(0, w + 400) - 200);
               cy = clamp_coord($urandom_range(0, h + 400) - 200);
            end else begin
               cx = $urandom_range(0, 16383) - 8192;
               cy = $urandom_range(0, 16383) - 8192;
            end
            r = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 400) : $urandom_range(0, 8191);
            send_circle(cx, cy, r);
            idle_gap(p < 8);
         end
         drain();
         settings_done++;
      end

      $display("Sent %0d circles over %0d screen settings, including empty and largest screens",
               circles_sent, settings_done);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/csot_pkg.sv
rtl/core/csot_edge.sv
rtl/core/circle_screen_overlap_test_top.sv
tb/circle_screen_overlap_test_checker.sv
tb/circle_screen_overlap_test_top_tb.sv
